@@ hw/rtl/asgt_pkg.sv @@
//------------------------------------------------------------------------------
// asgt_pkg
// shared constants and controller/datapath command and status types
//------------------------------------------------------------------------------
package asgt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 20;
    localparam int CFG_WIDTH       = 23;
    localparam int CFG_IDX_WIDTH   = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_GREEN = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_GREEN = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_YELLOW    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ALL_RED   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_CYCLE = 3'd4;

    localparam int RST_MIN_GREEN = 10000;
    localparam int RST_MAX_GREEN = 60000;
    localparam int RST_YELLOW    = 3000;
    localparam int RST_ALL_RED   = 1000;
    localparam int RST_MAX_CYCLE = 120000;
    localparam int INIT_GREEN    = 30000;
    localparam int STEP_MS       = 5000;

    localparam int OCC_FULL    = 1024;
    localparam int OCC_SUM_MAX = 4095;

    localparam int TGT_LOW   = 20000;
    localparam int TGT_MID   = 30000;
    localparam int TGT_HIGH  = 40000;
    localparam int TGT_PEAK  = 55000;
    localparam int DEM_LIM_0 = 614400;
    localparam int DEM_LIM_1 = 1228800;
    localparam int DEM_LIM_2 = 1843200;

    typedef struct packed {
        logic accum;
        logic clear;
        logic decide;
        logic check;
        logic div_start;
        logic div_step;
        logic split;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic eos;
        logic need_div;
        logic div_last;
    } t_status;

endpackage

@@ hw/rtl/asgt_ctrl.sv @@
//------------------------------------------------------------------------------
// asgt_ctrl
// sequencer: accumulate, decide, optional serial divide, output
//------------------------------------------------------------------------------
module asgt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  asgt_pkg::t_status i_st,
    output asgt_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       acc;

    assign o_stall = (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accum = acc;
                if (acc && i_st.eos) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                if (i_st.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) n_state = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.clear  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_out_only_from_div_or_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) != S_OUT) |->
        ($past(r_state) == S_CHK || $past(r_state) == S_SPLIT))
        else $error("output entered from bad state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accum |-> r_state == S_IDLE)
        else $error("accumulate while busy");
    a_finish_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("finish did not return to idle");

endmodule

@@ hw/rtl/asgt_dp.sv @@
//------------------------------------------------------------------------------
// asgt_dp
// accumulators, green decision, clamp, cycle check and restoring divider
//------------------------------------------------------------------------------
module asgt_dp #(
    parameter int COUNT_WIDTH = asgt_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = asgt_pkg::TIME_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  asgt_pkg::t_cmd         i_cmd,
    output asgt_pkg::t_status      o_st,
    input  logic                   i_cfg_we,
    input  logic [asgt_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [TIME_WIDTH+2:0]  i_cfg_data,
    input  logic [1:0]             i_approach,
    input  logic [COUNT_WIDTH-1:0] i_queue_length,
    input  logic [COUNT_WIDTH-1:0] i_vehicle_count,
    input  logic [10:0]            i_occupancy,
    input  logic                   i_emergency,
    input  logic                   i_end_of_snapshot,
    output logic [31:0]            o_plan_number,
    output logic [TIME_WIDTH-1:0]  o_green_ns_ms,
    output logic [TIME_WIDTH-1:0]  o_green_ew_ms,
    output logic [TIME_WIDTH-1:0]  o_plan_yellow_ms,
    output logic [TIME_WIDTH-1:0]  o_plan_all_red_ms,
    output logic [TIME_WIDTH+2:0]  o_cycle_length_ms,
    output logic                   o_emergency_ns_active,
    output logic                   o_emergency_ew_active
);

    localparam int SW  = COUNT_WIDTH + 1;
    localparam int TW  = TIME_WIDTH;
    localparam int CW  = TIME_WIDTH + 3;
    localparam int DW  = SW + 14;
    localparam int NW  = TW + CW;
    localparam int DCW = $clog2(NW + 1);
    localparam logic [SW-1:0] SUM_MAX = '1;
    localparam logic [CW-1:0] CYC_MAX = '1;
    localparam logic [TW-1:0] TIME_MAX = '1;

    logic [TW-1:0] r_min, r_max, r_yel, r_red;
    logic [CW-1:0] r_mcyc;
    logic [SW-1:0] r_q_ns, r_q_ew, r_c_ns, r_c_ew;
    logic [11:0]   r_o_ns, r_o_ew;
    logic [1:0]    r_em;
    logic [TW-1:0] r_prev_ns, r_prev_ew;
    logic [31:0]   r_plan;
    logic [TW-1:0] r_gns, r_gew;
    logic [CW-1:0] r_avail;
    logic [TW:0]   r_total;
    logic [NW-1:0] r_quo;
    logic [TW+1:0] r_rem;
    logic [DCW-1:0] r_dcnt;

    // accumulate
    logic [10:0]   occ_c;
    logic [SW:0]   q_add, c_add;
    logic [12:0]   o_add;
    logic          is_ns;

    assign occ_c = (i_occupancy > 11'(asgt_pkg::OCC_FULL)) ? 11'(asgt_pkg::OCC_FULL)
                                                           : i_occupancy;
    assign is_ns = !i_approach[1];
    assign q_add = (is_ns ? {1'b0, r_q_ns} : {1'b0, r_q_ew}) + (SW+1)'(i_queue_length);
    assign c_add = (is_ns ? {1'b0, r_c_ns} : {1'b0, r_c_ew}) + (SW+1)'(i_vehicle_count);
    assign o_add = (is_ns ? {1'b0, r_o_ns} : {1'b0, r_o_ew}) + 13'(occ_c);

    logic [SW-1:0] q_sat, c_sat;
    logic [11:0]   o_sat;
    assign q_sat = q_add[SW] ? SUM_MAX : q_add[SW-1:0];
    assign c_sat = c_add[SW] ? SUM_MAX : c_add[SW-1:0];
    assign o_sat = (o_add > 13'(asgt_pkg::OCC_SUM_MAX)) ? 12'(asgt_pkg::OCC_SUM_MAX)
                                                       : o_add[11:0];

    // decision
    function automatic logic [TW:0] f_target(logic [SW-1:0] q, logic [SW-1:0] c,
                                              logic [11:0] o);
        logic [DW-1:0] d;
        d = DW'({q, 12'd0}) + DW'({q, 10'd0}) + DW'({c, 11'd0}) + DW'({c, 10'd0})
          + DW'(o) * DW'(200);
        if (d < DW'(asgt_pkg::DEM_LIM_0))      return (TW+1)'(asgt_pkg::TGT_LOW);
        else if (d < DW'(asgt_pkg::DEM_LIM_1)) return (TW+1)'(asgt_pkg::TGT_MID);
        else if (d < DW'(asgt_pkg::DEM_LIM_2)) return (TW+1)'(asgt_pkg::TGT_HIGH);
        else                                   return (TW+1)'(asgt_pkg::TGT_PEAK);
    endfunction

    function automatic logic [TW-1:0] f_step(logic [TW-1:0] cur, logic [TW:0] tgt);
        logic [TW+1:0] c1, t1;
        c1 = (TW+2)'(cur);
        t1 = (TW+2)'(tgt);
        if (c1 < t1) begin
            return (c1 + (TW+2)'(asgt_pkg::STEP_MS) < t1)
                ? TW'(c1 + (TW+2)'(asgt_pkg::STEP_MS)) : TW'(t1);
        end else if (c1 > t1) begin
            return (c1 - t1 > (TW+2)'(asgt_pkg::STEP_MS))
                ? TW'(c1 - (TW+2)'(asgt_pkg::STEP_MS)) : TW'(t1);
        end
        return cur;
    endfunction

    function automatic logic [TW-1:0] f_clamp(logic [TW-1:0] v, logic [TW-1:0] lo,
                                               logic [TW-1:0] hi);
        if (v < lo)      return lo;
        else if (v > hi) return hi;
        return v;
    endfunction

    logic [TW-1:0] dec_ns, dec_ew;
    always_comb begin
        if (r_em != 2'b00) begin
            dec_ns = r_prev_ns;
            dec_ew = r_prev_ew;
        end else begin
            dec_ns = f_step(r_prev_ns, f_target(r_q_ns, r_c_ns, r_o_ns));
            dec_ew = f_step(r_prev_ew, f_target(r_q_ew, r_c_ew, r_o_ew));
        end
    end

    // cycle
    logic [CW:0]   inter, cyc_raw, avail_w;
    logic [CW-1:0] cyc_sat;
    logic [TW:0]   tot;
    logic          over_w, fill_w, need_w;
    assign inter   = (CW+1)'({1'b0, r_yel} + {1'b0, r_red}) << 1;
    assign tot     = {1'b0, r_gns} + {1'b0, r_gew};
    assign cyc_raw = (CW+1)'(tot) + inter;
    assign cyc_sat = cyc_raw[CW] || cyc_raw[CW-1:0] == CYC_MAX ? CYC_MAX
                   : cyc_raw[CW-1:0];
    assign avail_w = (CW+1)'(r_mcyc) - inter;
    assign over_w  = cyc_sat > r_mcyc;
    assign fill_w  = over_w && (r_mcyc <= inter[CW-1:0] || inter[CW]);
    assign need_w  = over_w && !fill_w && ((CW+1)'(tot) > avail_w);

    // restoring divider: quotient register shifts dividend bits out into the remainder and quotient bits in
    logic [TW+2:0] rem_sh;
    logic [TW+2:0] rem_sub;
    assign rem_sh  = {r_rem, r_quo[NW-1]};
    assign rem_sub = rem_sh - (TW+3)'(r_total);

    // split
    logic [CW:0] ns_q, ns_c, ew_w, amm;
    assign ns_q = (r_quo[NW-1:CW+1] != '0) ? '1 : r_quo[CW:0];
    assign amm  = (CW+1)'(r_avail) - (CW+1)'(r_min);
    always_comb begin
        if (ns_q < (CW+1)'(r_min))
            ns_c = (CW+1)'(r_min);
        else if (r_avail >= CW'(r_min) && ns_q > amm)
            ns_c = amm;
        else
            ns_c = ns_q;
        ew_w = (ns_c > (CW+1)'(r_avail)) ? '0 : (CW+1)'(r_avail) - ns_c;
    end

    assign o_st.eos      = i_end_of_snapshot;
    assign o_st.need_div = need_w;
    assign o_st.div_last = (r_dcnt == DCW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= TW'(asgt_pkg::RST_MIN_GREEN);
            r_max  <= TW'(asgt_pkg::RST_MAX_GREEN);
            r_yel  <= TW'(asgt_pkg::RST_YELLOW);
            r_red  <= TW'(asgt_pkg::RST_ALL_RED);
            r_mcyc <= CW'(asgt_pkg::RST_MAX_CYCLE);
            r_q_ns <= '0; r_q_ew <= '0; r_c_ns <= '0; r_c_ew <= '0;
            r_o_ns <= '0; r_o_ew <= '0; r_em <= '0;
            r_prev_ns <= TW'(asgt_pkg::INIT_GREEN);
            r_prev_ew <= TW'(asgt_pkg::INIT_GREEN);
            r_plan <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    asgt_pkg::REG_MIN_GREEN: r_min  <= i_cfg_data[TW-1:0];
                    asgt_pkg::REG_MAX_GREEN: r_max  <= i_cfg_data[TW-1:0];
                    asgt_pkg::REG_YELLOW:    r_yel  <= i_cfg_data[TW-1:0];
                    asgt_pkg::REG_ALL_RED:   r_red  <= i_cfg_data[TW-1:0];
                    asgt_pkg::REG_MAX_CYCLE: r_mcyc <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accum) begin
                if (is_ns) begin
                    r_q_ns <= q_sat; r_c_ns <= c_sat; r_o_ns <= o_sat;
                    r_em[0] <= r_em[0] | i_emergency;
                end else begin
                    r_q_ew <= q_sat; r_c_ew <= c_sat; r_o_ew <= o_sat;
                    r_em[1] <= r_em[1] | i_emergency;
                end
            end
            if (i_cmd.div_start) r_dcnt <= DCW'(NW);
            else if (i_cmd.div_step) r_dcnt <= r_dcnt - DCW'(1);
            if (i_cmd.finish) begin
                r_plan    <= r_plan + 32'd1;
                r_prev_ns <= r_gns;
                r_prev_ew <= r_gew;
            end
            if (i_cmd.clear) begin
                r_q_ns <= '0; r_q_ew <= '0; r_c_ns <= '0; r_c_ew <= '0;
                r_o_ns <= '0; r_o_ew <= '0; r_em <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_gns <= f_clamp(dec_ns, r_min, r_max);
            r_gew <= f_clamp(dec_ew, r_min, r_max);
        end
        if (i_cmd.check && fill_w) begin
            r_gns <= r_min;
            r_gew <= r_min;
        end
        if (i_cmd.div_start) begin
            r_avail <= avail_w[CW-1:0];
            r_total <= tot;
            r_quo   <= NW'(r_gns) * NW'(avail_w[CW-1:0]);
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            if (!rem_sub[TW+2]) begin
                r_rem <= rem_sub[TW+1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[TW+1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
        if (i_cmd.split) begin
            r_gns <= TW'(ns_c);
            r_gew <= (ew_w > (CW+1)'(TIME_MAX)) ? TIME_MAX : TW'(ew_w);
        end
    end

    assign o_plan_number         = r_plan;
    assign o_green_ns_ms         = r_gns;
    assign o_green_ew_ms         = r_gew;
    assign o_plan_yellow_ms      = r_yel;
    assign o_plan_all_red_ms     = r_red;
    assign o_cycle_length_ms     = cyc_sat;
    assign o_emergency_ns_active = r_em[0];
    assign o_emergency_ew_active = r_em[1];

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_em == 2'b00 && r_q_ns == '0 && r_q_ew == '0))
        else $error("sums not cleared");
    a_plan_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_plan == $past(r_plan) + 32'd1)
        else $error("plan counter did not advance");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dcnt == DCW'(NW))
        else $error("divider count not loaded");

endmodule

@@ hw/rtl/adaptive_signal_green_timing_core.sv @@
//------------------------------------------------------------------------------
// adaptive_signal_green_timing_core
// per-approach measurements in, one two-axis green plan per snapshot out
//------------------------------------------------------------------------------
// One measurement beat is taken per cycle while idle. The closing beat passes
// through the decide and check states to the plan beat, with the divide and
// split states between them when the cycle is over the limit and the split is
// rescaled by the bit-serial restoring divider. The input stalls until the plan
// beat is taken.
module adaptive_signal_green_timing_core #(
    parameter int COUNT_WIDTH = asgt_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = asgt_pkg::TIME_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [asgt_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [TIME_WIDTH+2:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_approach,
    input  logic [COUNT_WIDTH-1:0] i_queue_length,
    input  logic [COUNT_WIDTH-1:0] i_vehicle_count,
    input  logic [10:0]            i_occupancy,
    input  logic                   i_emergency,
    input  logic                   i_end_of_snapshot,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_plan_number,
    output logic [TIME_WIDTH-1:0]  o_green_ns_ms,
    output logic [TIME_WIDTH-1:0]  o_green_ew_ms,
    output logic [TIME_WIDTH-1:0]  o_plan_yellow_ms,
    output logic [TIME_WIDTH-1:0]  o_plan_all_red_ms,
    output logic [TIME_WIDTH+2:0]  o_cycle_length_ms,
    output logic                   o_emergency_ns_active,
    output logic                   o_emergency_ew_active
);

    asgt_pkg::t_cmd    cmd;
    asgt_pkg::t_status st;

    asgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    asgt_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_st                  (st),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_approach            (i_approach),
        .i_queue_length        (i_queue_length),
        .i_vehicle_count       (i_vehicle_count),
        .i_occupancy           (i_occupancy),
        .i_emergency           (i_emergency),
        .i_end_of_snapshot     (i_end_of_snapshot),
        .o_plan_number         (o_plan_number),
        .o_green_ns_ms         (o_green_ns_ms),
        .o_green_ew_ms         (o_green_ew_ms),
        .o_plan_yellow_ms      (o_plan_yellow_ms),
        .o_plan_all_red_ms     (o_plan_all_red_ms),
        .o_cycle_length_ms     (o_cycle_length_ms),
        .o_emergency_ns_active (o_emergency_ns_active),
        .o_emergency_ew_active (o_emergency_ew_active)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// drives measurement beats into adaptive_signal_green_timing_core, predicts
// every green plan in a behavioral model and checks each plan beat in order
//------------------------------------------------------------------------------
module testbench;

    localparam int TW = 20;
    localparam int CW = 16;
    localparam longint TIME_MAX  = (64'd1 << TW) - 1;
    localparam longint CYCLE_MAX = (64'd1 << (TW + 3)) - 1;
    localparam longint SUM_MAX   = (64'd1 << (CW + 1)) - 1;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic [1:0]    approach;
        logic [CW-1:0] queue_length;
        logic [CW-1:0] vehicle_count;
        logic [10:0]   occupancy;
        logic          emergency;
        logic          eos;
    } t_meas;

    typedef struct packed {
        logic [31:0]   plan_number;
        logic [TW-1:0] green_ns;
        logic [TW-1:0] green_ew;
        logic [TW-1:0] yellow;
        logic [TW-1:0] all_red;
        logic [TW+2:0] cycle_len;
        logic          emg_ns;
        logic          emg_ew;
    } t_plan;

    typedef struct {
        t_meas  m;
        logic   has_plan;
        t_plan  p;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [asgt_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx = '0;
    logic [TW+2:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_meas meas_drv = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    t_plan plan_out;

    always #10 i_clk = ~i_clk;

    adaptive_signal_green_timing_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_approach(meas_drv.approach), .i_queue_length(meas_drv.queue_length),
        .i_vehicle_count(meas_drv.vehicle_count), .i_occupancy(meas_drv.occupancy),
        .i_emergency(meas_drv.emergency), .i_end_of_snapshot(meas_drv.eos),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_plan_number(plan_out.plan_number), .o_green_ns_ms(plan_out.green_ns),
        .o_green_ew_ms(plan_out.green_ew), .o_plan_yellow_ms(plan_out.yellow),
        .o_plan_all_red_ms(plan_out.all_red), .o_cycle_length_ms(plan_out.cycle_len),
        .o_emergency_ns_active(plan_out.emg_ns), .o_emergency_ew_active(plan_out.emg_ew)
    );

    // predictor state
    longint cfg_min, cfg_max, cfg_yel, cfg_red, cfg_cyc;
    longint q_ns, q_ew, c_ns, c_ew, o_ns, o_ew;
    logic [1:0] emg_seen;
    longint prev_ns, prev_ew;
    logic [31:0] plan_cnt;

    t_plan plans_due[$];
    int mismatches = 0;
    int cycles = 0;
    bit stim_done = 1'b0;
    bit hold_rx = 1'b0;
    bit typed_due = 1'b0;
    t_plan typed_plan;

    function automatic longint sat(longint a, longint b, longint top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic longint green_target(longint q, longint c, longint o);
        longint d;
        d = 5120 * q + 3072 * c + 200 * o;
        if (d < asgt_pkg::DEM_LIM_0) return asgt_pkg::TGT_LOW;
        if (d < asgt_pkg::DEM_LIM_1) return asgt_pkg::TGT_MID;
        if (d < asgt_pkg::DEM_LIM_2) return asgt_pkg::TGT_HIGH;
        return asgt_pkg::TGT_PEAK;
    endfunction

    function automatic longint step_green(longint cur, longint tgt);
        if (cur < tgt) begin
            return (cur + asgt_pkg::STEP_MS < tgt) ? cur + asgt_pkg::STEP_MS : tgt;
        end
        if (cur > tgt) begin
            return (cur - tgt > asgt_pkg::STEP_MS) ? cur - asgt_pkg::STEP_MS : tgt;
        end
        return cur;
    endfunction

    function automatic longint clamp_green(longint v);
        if (v < cfg_min) return cfg_min;
        if (v > cfg_max) return cfg_max;
        return v;
    endfunction

    function automatic longint cycle_sum(longint a, longint b);
        longint v;
        v = a + b + 2 * (cfg_yel + cfg_red);
        return v > CYCLE_MAX ? CYCLE_MAX : v;
    endfunction

    task automatic write_reg(logic [asgt_pkg::CFG_IDX_WIDTH-1:0] idx, longint val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[TW+2:0];
        @(posedge i_clk);
        case (idx)
            asgt_pkg::REG_MIN_GREEN: cfg_min = val & TIME_MAX;
            asgt_pkg::REG_MAX_GREEN: cfg_max = val & TIME_MAX;
            asgt_pkg::REG_YELLOW:    cfg_yel = val & TIME_MAX;
            asgt_pkg::REG_ALL_RED:   cfg_red = val & TIME_MAX;
            asgt_pkg::REG_MAX_CYCLE: cfg_cyc = val & CYCLE_MAX;
            default: ;
        endcase
    endtask

    task automatic predict_plan(t_meas m);
        longint occ, gns, gew, inter, avail, total, ns, cyc;
        bit emg;
        t_plan p;
        occ = (longint'(m.occupancy) > asgt_pkg::OCC_FULL) ? asgt_pkg::OCC_FULL
                                                           : longint'(m.occupancy);
        if (m.approach < 2) begin
            q_ns = sat(q_ns, longint'(m.queue_length), SUM_MAX);
            c_ns = sat(c_ns, longint'(m.vehicle_count), SUM_MAX);
            o_ns = sat(o_ns, occ, asgt_pkg::OCC_SUM_MAX);
            emg_seen[0] |= m.emergency;
        end else begin
            q_ew = sat(q_ew, longint'(m.queue_length), SUM_MAX);
            c_ew = sat(c_ew, longint'(m.vehicle_count), SUM_MAX);
            o_ew = sat(o_ew, occ, asgt_pkg::OCC_SUM_MAX);
            emg_seen[1] |= m.emergency;
        end
        if (!m.eos) return;
        emg = emg_seen != 0;
        if (emg) begin
            gns = prev_ns;
            gew = prev_ew;
        end else begin
            gns = step_green(prev_ns, green_target(q_ns, c_ns, o_ns));
            gew = step_green(prev_ew, green_target(q_ew, c_ew, o_ew));
        end
        gns = clamp_green(gns);
        gew = clamp_green(gew);
        if (cycle_sum(gns, gew) > cfg_cyc) begin
            inter = 2 * (cfg_yel + cfg_red);
            if (cfg_cyc <= inter) begin
                gns = cfg_min;
                gew = cfg_min;
            end else begin
                avail = cfg_cyc - inter;
                total = gns + gew;
                if (total > avail && total != 0) begin
                    ns = (gns * avail) / total;
                    if (ns < cfg_min) ns = cfg_min;
                    else if (avail >= cfg_min && ns > avail - cfg_min) ns = avail - cfg_min;
                    gns = ns;
                    gew = ns > avail ? 0 : avail - ns;
                    if (gew > TIME_MAX) gew = TIME_MAX;
                end
            end
        end
        cyc = cycle_sum(gns, gew);
        p.plan_number = plan_cnt;
        p.green_ns = gns[TW-1:0];
        p.green_ew = gew[TW-1:0];
        p.yellow = cfg_yel[TW-1:0];
        p.all_red = cfg_red[TW-1:0];
        p.cycle_len = cyc[TW+2:0];
        p.emg_ns = emg & emg_seen[0];
        p.emg_ew = emg & emg_seen[1];
        plans_due.push_back(p);
        plan_cnt++;
        prev_ns = gns & TIME_MAX;
        prev_ew = gew & TIME_MAX;
        q_ns = 0; q_ew = 0; c_ns = 0; c_ew = 0; o_ns = 0; o_ew = 0;
        emg_seen = '0;
    endtask

    task automatic send_beat(t_meas m, bit gaps);
        int g;
        g = 0;
        if (gaps) begin
            g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        end
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        meas_drv <= m;
        do @(posedge i_clk); while (o_stall);
        predict_plan(m);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (plans_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_meas rand_meas(bit eos);
        t_meas m;
        int k;
        m.approach = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 9);
        m.queue_length = (k == 0) ? 16'hffff
                       : (k < 3) ? 16'($urandom) : 16'($urandom_range(0, 120));
        k = $urandom_range(0, 9);
        m.vehicle_count = (k == 0) ? 16'hffff
                        : (k < 3) ? 16'($urandom) : 16'($urandom_range(0, 200));
        m.occupancy = ($urandom_range(0, 7) == 0) ? 11'($urandom)
                                                  : 11'($urandom_range(0, 1024));
        m.emergency = ($urandom_range(0, 11) == 0);
        m.eos = eos;
        return m;
    endfunction

    // receiver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (plans_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected plan beat %p", plan_out);
            end else begin
                t_plan e;
                e = plans_due.pop_front();
                if (e !== plan_out) begin
                    mismatches++;
                    if (mismatches <= 10) $display("plan mismatch exp %p act %p", e, plan_out);
                end
            end
        end
        if (hold_rx) i_stall <= 1'b1;
        else if (!stim_done && $urandom_range(0, 29) == 0) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(0, 3) == 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("adaptive_signal_green_timing_core regression: fail");
            $finish;
        end
    end

    // check of typed-in rows against the predictor's queue
    always @(posedge i_clk) begin
        if (typed_due && plans_due.size() != 0) begin
            if (plans_due[plans_due.size()-1] !== typed_plan) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row exp %p model %p", typed_plan, plans_due[$]);
            end
            typed_due <= 1'b0;
        end
    end

    // long receiver hold-off
    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    t_row rows[$];

    function automatic t_row mk(logic [1:0] a, int q, int c, int o, bit em, bit eos,
                                bit has, t_plan p);
        t_row r;
        r.m = '{a, q[CW-1:0], c[CW-1:0], o[10:0], em, eos};
        r.has_plan = has;
        r.p = p;
        return r;
    endfunction

    initial begin
        int n, len;
        longint v;
        t_meas m;
        cfg_min = asgt_pkg::RST_MIN_GREEN; cfg_max = asgt_pkg::RST_MAX_GREEN;
        cfg_yel = asgt_pkg::RST_YELLOW; cfg_red = asgt_pkg::RST_ALL_RED;
        cfg_cyc = asgt_pkg::RST_MAX_CYCLE;
        q_ns = 0; q_ew = 0; c_ns = 0; c_ew = 0; o_ns = 0; o_ew = 0;
        emg_seen = '0; prev_ns = asgt_pkg::INIT_GREEN; prev_ew = asgt_pkg::INIT_GREEN;
        plan_cnt = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: typed plans after reset, empty snapshot and emergency
        rows.push_back(mk(0, 0, 0, 0, 0, 1, 1, '{0, 25000, 25000, 3000, 1000, 58000, 0, 0}));
        rows.push_back(mk(2, 0, 0, 0, 1, 1, 1, '{1, 25000, 25000, 3000, 1000, 58000, 0, 1}));
        rows.push_back(mk(1, 0, 0, 0, 1, 0, 0, '0));
        rows.push_back(mk(3, 0, 0, 0, 1, 1, 1, '{2, 25000, 25000, 3000, 1000, 58000, 1, 1}));
        rows.push_back(mk(0, 65535, 65535, 2047, 0, 0, 0, '0));
        rows.push_back(mk(1, 65535, 65535, 2047, 0, 0, 0, '0));
        rows.push_back(mk(2, 65535, 65535, 1024, 0, 0, 0, '0));
        rows.push_back(mk(3, 65535, 65535, 1025, 0, 1, 0, '0));
        rows.push_back(mk(0, 120, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(2, 0, 200, 0, 0, 1, 0, '0));
        rows.push_back(mk(1, 0, 0, 1024, 0, 0, 0, '0));
        rows.push_back(mk(3, 240, 0, 0, 0, 1, 0, '0));
        for (int i = 0; i < 6; i++) rows.push_back(mk(2'(i % 4), 65535, 0, 0, 0, 1, 0, '0));
        foreach (rows[i]) begin
            send_beat(rows[i].m, 1'b0);
            if (rows[i].has_plan) begin
                i_valid <= 1'b0;
                typed_plan = rows[i].p;
                typed_due = 1'b1;
                @(posedge i_clk);
                while (typed_due) @(posedge i_clk);
            end
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(asgt_pkg::REG_MIN_GREEN, 0);
                    write_reg(asgt_pkg::REG_MAX_GREEN, TIME_MAX);
                    write_reg(asgt_pkg::REG_MAX_CYCLE, CYCLE_MAX);
                end
                2: begin
                    write_reg(asgt_pkg::REG_MIN_GREEN, 45000);
                    write_reg(asgt_pkg::REG_MAX_GREEN, 20000);
                end
                3: begin
                    write_reg(asgt_pkg::REG_MIN_GREEN, 15000);
                    write_reg(asgt_pkg::REG_MAX_GREEN, 55000);
                    write_reg(asgt_pkg::REG_MAX_CYCLE, 60000);
                end
                4: begin
                    write_reg(asgt_pkg::REG_YELLOW, TIME_MAX);
                    write_reg(asgt_pkg::REG_ALL_RED, TIME_MAX);
                    write_reg(asgt_pkg::REG_MAX_CYCLE, 5000);
                end
                5: begin
                    write_reg(asgt_pkg::REG_YELLOW, 0); write_reg(asgt_pkg::REG_ALL_RED, 0);
                    write_reg(asgt_pkg::REG_MIN_GREEN, 40000);
                    write_reg(asgt_pkg::REG_MAX_CYCLE, 50000);
                end
                6: begin
                    write_reg(asgt_pkg::REG_MIN_GREEN, TIME_MAX);
                    write_reg(asgt_pkg::REG_MAX_GREEN, TIME_MAX);
                    write_reg(asgt_pkg::REG_MAX_CYCLE, CYCLE_MAX);
                end
                default: begin
                    v = $urandom_range(0, 30000); write_reg(asgt_pkg::REG_MIN_GREEN, v);
                    write_reg(asgt_pkg::REG_MAX_GREEN, v + $urandom_range(0, 60000));
                    write_reg(asgt_pkg::REG_YELLOW, $urandom_range(0, 6000));
                    write_reg(asgt_pkg::REG_ALL_RED, $urandom_range(0, 3000));
                    write_reg(asgt_pkg::REG_MAX_CYCLE, $urandom_range(20000, 150000));
                end
            endcase
            i_cfg_we <= 1'b0;
            n = 0;
            while (n < 240) begin
                if ($urandom_range(0, 9) == 0) begin
                    m = rand_meas($urandom_range(0, 3) == 0);
                    send_beat(m, 1'b1);
                    n++;
                end else begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++) begin
                        m = rand_meas(k == len - 1);
                        send_beat(m, 1'b1);
                        n++;
                    end
                end
            end
            drain();
        end
        stim_done = 1'b1;
        drain();
        if (mismatches == 0 && plans_due.size() == 0)
            $display("adaptive_signal_green_timing_core regression: pass");
        else
            $display("adaptive_signal_green_timing_core regression: fail");
        $finish;
    end
endmodule
